/* rtl/assert_macros.svh */
// Assertion helpers used by the RTL top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: implication");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

/* rtl/rsx_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package rsx_pkg;

  localparam logic [5:0] RADIX_MIN   = 6'd2;
  localparam logic [5:0] RADIX_MAX   = 6'd36;
  localparam logic [5:0] DIGIT_LIMIT = 6'd36;
  localparam logic [5:0] DEC_DIGITS  = 6'd10;
  localparam logic [6:0] MINUS_CHAR  = 7'h2d;
  localparam logic [6:0] NUL_CHAR    = 7'h00;
  localparam logic [6:0] ZERO_CHAR   = 7'h30;
  localparam logic [6:0] ALPHA_CHAR  = 7'h61;
  localparam logic       REG_RADIX   = 1'b0;

  // Per-number control carried through the queue.
  typedef struct packed {
    logic       neg;
    logic       bad;
    logic [5:0] radix;
  } rsx_job_t;

  // Digit value to lower-case ASCII; out-of-range values give '0'.
  function automatic logic [6:0] digit_char(input logic [5:0] d);
    logic [6:0] ch;
    if (d < DEC_DIGITS) begin
      ch = ZERO_CHAR + {1'b0, d};
    end else if (d < DIGIT_LIMIT) begin
      ch = ALPHA_CHAR + {1'b0, d - DEC_DIGITS};
    end else begin
      ch = ZERO_CHAR;
    end
    return ch;
  endfunction

endpackage

`default_nettype wire

/* rtl/rsx_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module rsx_ram #(
  parameter int WIDTH = 6,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* rtl/rsx_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module rsx_front import rsx_pkg::*; #(
  parameter int VALUE_BITS = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [31:0]           s_tdata,
  input  wire logic [5:0]            radix,
  output logic                       q_valid,
  input  wire logic                  q_ready,
  output logic      [VALUE_BITS-1:0] q_mag,
  output rsx_job_t                   q_job
);

  logic [VALUE_BITS-1:0] raw;
  logic [VALUE_BITS-1:0] mag_in;
  rsx_job_t              job_in;

  logic [VALUE_BITS-1:0] mag_mem [2];
  rsx_job_t              job_mem [2];
  logic                  wr_ptr;
  logic                  rd_ptr;
  logic [1:0]            fill;
  logic                  push;
  logic                  pop;

  // Classify: sign, radix validity, magnitude (most negative value wraps to itself, read unsigned).
  always_comb begin
    raw          = VALUE_BITS'(s_tdata);
    job_in.neg   = raw[VALUE_BITS-1];
    job_in.bad   = (radix < RADIX_MIN) || (radix > RADIX_MAX);
    job_in.radix = radix;
    mag_in       = job_in.neg ? (~raw + 1'b1) : raw;
  end

  assign s_tready = (fill != 2'd2);
  assign q_valid  = (fill != 2'd0);
  assign push     = s_tvalid && s_tready;
  assign pop      = q_valid && q_ready;
  assign q_mag    = mag_mem[rd_ptr];
  assign q_job    = job_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mag_mem[wr_ptr] <= mag_in;
      job_mem[wr_ptr] <= job_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

`default_nettype wire

/* rtl/rsx_back.sv */
`timescale 1ns / 1ps
`default_nettype none

module rsx_back import rsx_pkg::*; #(
  parameter int VALUE_BITS = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  q_valid,
  output logic                       q_ready,
  input  wire logic [VALUE_BITS-1:0] q_mag,
  input  rsx_job_t                   q_job,
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic      [7:0]            m_tdata,
  output logic                       m_tlast
);

  localparam int STEP_BITS = 8;
  localparam int NSTEPS    = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
  localparam int PAD_BITS  = NSTEPS * STEP_BITS;
  localparam int STEP_W    = (NSTEPS > 1) ? $clog2(NSTEPS) : 1;
  localparam int CNT_W     = $clog2(VALUE_BITS + 1);
  localparam int ADDR_W    = $clog2(VALUE_BITS);

  typedef enum logic [1:0] {IDLE, DIV, EMIT, FIN} state_t;

  state_t              state;
  logic [PAD_BITS-1:0] sh;
  logic [PAD_BITS-1:0] sh_next;
  logic [6:0]          rem;
  logic [6:0]          rem_next;
  logic [5:0]          radix_r;
  logic [STEP_W-1:0]   step;
  logic [CNT_W-1:0]    cnt;
  logic [CNT_W-1:0]    cnt_dec;
  logic                sign;
  logic                pend;
  logic                step_last;
  logic                slot_free;
  logic                rd_issue;
  logic                beat_load;
  logic [5:0]          rd_data;

  // One radix-digit division: STEP_BITS quotient bits per cycle, restoring.
  always_comb begin
    rem_next = rem;
    sh_next  = sh;
    for (int i = 0; i < STEP_BITS; i++) begin
      rem_next = {rem_next[5:0], sh_next[PAD_BITS-1]};
      sh_next  = {sh_next[PAD_BITS-2:0], 1'b0};
      if (rem_next >= {1'b0, radix_r}) begin
        rem_next   = rem_next - {1'b0, radix_r};
        sh_next[0] = 1'b1;
      end
    end
  end

  assign step_last = (step == STEP_W'(NSTEPS - 1));
  assign slot_free = !m_tvalid || m_tready;
  assign cnt_dec   = cnt - 1'b1;
  assign q_ready   = (state == IDLE);
  // Prefetch next stack entry; read data holds while no read is issued.
  assign rd_issue  = (state == EMIT) && (!pend || (!sign && slot_free && (cnt != '0)));
  // A new beat goes into the output register this cycle.
  assign beat_load = slot_free && (((state == EMIT) && (sign || pend)) || (state == FIN));

  rsx_ram #(
    .WIDTH (6),
    .DEPTH (VALUE_BITS)
  ) u_stack (
    .clk   (clk),
    .we    ((state == DIV) && step_last),
    .waddr (cnt[ADDR_W-1:0]),
    .wdata (rem_next[5:0]),
    .re    (rd_issue),
    .raddr (cnt_dec[ADDR_W-1:0]),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      m_tvalid <= 1'b0;
      pend     <= 1'b0;
      sign     <= 1'b0;
      cnt      <= '0;
    end else begin
      if (m_tvalid && m_tready && !beat_load) begin
        m_tvalid <= 1'b0;
      end
      if (rd_issue) begin
        cnt <= cnt_dec;
      end
      unique case (state)
        IDLE: begin
          if (q_valid) begin
            if (q_job.bad) begin
              state <= FIN;
            end else begin
              sh      <= PAD_BITS'(q_mag);
              radix_r <= q_job.radix;
              sign    <= q_job.neg;
              rem     <= '0;
              step    <= '0;
              cnt     <= '0;
              state   <= DIV;
            end
          end
        end
        DIV: begin
          sh   <= sh_next;
          rem  <= rem_next;
          step <= step + 1'b1;
          if (step_last) begin
            step <= '0;
            rem  <= '0;
            cnt  <= cnt + 1'b1;
            if (sh_next == '0) begin
              pend  <= 1'b0;
              state <= EMIT;
            end
          end
        end
        EMIT: begin
          if (!pend) begin
            pend <= 1'b1;
            if (sign && slot_free) begin
              m_tvalid <= 1'b1;
              m_tdata  <= {1'b0, MINUS_CHAR};
              m_tlast  <= 1'b0;
              sign     <= 1'b0;
            end
          end else if (sign) begin
            if (slot_free) begin
              m_tvalid <= 1'b1;
              m_tdata  <= {1'b0, MINUS_CHAR};
              m_tlast  <= 1'b0;
              sign     <= 1'b0;
            end
          end else if (slot_free) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {1'b0, digit_char(rd_data)};
            m_tlast  <= 1'b0;
            if (cnt == '0) begin
              pend  <= 1'b0;
              state <= FIN;
            end
          end
        end
        FIN: begin
          if (slot_free) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {1'b0, NUL_CHAR};
            m_tlast  <= 1'b1;
            state    <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/signed_integer_to_radix_text.sv */
// Channel  Dir  Beat contents
// s_*      in   tdata[31:0] number (two's complement)
// m_*      out  tdata[6:0] text_char, tdata[7] zero; tlast final_char
// APB      in   radix at byte address 0 (bits 5:0)
//
// Each digit is one full pass of the shared restoring divider over the
// magnitude; the characters then leave at one per cycle through the digit
// stack RAM while m_tready is high.
// A two-entry queue lets new numbers be taken while the back end works.
// rst is synchronous and clears control state; the digit stack needs no clear.
// Output stalls hold the back end in EMIT or FIN; the queue then fills and drops s_tready.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module signed_integer_to_radix_text import rsx_pkg::*; #(
  parameter int VALUE_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // [31:0] number
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [7:0]  m_tdata,   // [6:0] text_char, [7] zero
  output logic             m_tlast,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  logic                  cfg_wr;
  logic [5:0]            radix;
  logic                  q_valid;
  logic                  q_ready;
  logic [VALUE_BITS-1:0] q_mag;
  rsx_job_t              q_job;
  logic                  q_pop_bad;
  logic                  q_radix_bad;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_RADIX);
  assign prdata = (paddr[2] == REG_RADIX) ? {26'd0, radix} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      radix <= 6'd10;
    end else if (cfg_wr) begin
      radix <= pwdata[5:0];
    end
  end

  rsx_front #(
    .VALUE_BITS (VALUE_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .radix    (radix),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_mag    (q_mag),
    .q_job    (q_job)
  );

  rsx_back #(
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_mag    (q_mag),
    .q_job    (q_job),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  assign q_pop_bad   = q_valid && q_ready && q_job.bad;
  assign q_radix_bad = (q_job.radix < RADIX_MIN) || (q_job.radix > RADIX_MAX);

  `ASSERT_IMPLIES(a_last_is_nul, clk, rst, m_tvalid && m_tlast, m_tdata == 8'd0)
  `ASSERT_IMPLIES(a_body_not_nul, clk, rst, m_tvalid && !m_tlast, m_tdata[6:0] != NUL_CHAR)
  `ASSERT_NEXT(a_radix_write, clk, rst, cfg_wr, radix == $past(pwdata[5:0]))
  `ASSERT_IMPLIES(a_bad_job_no_digits, clk, rst, q_pop_bad, q_radix_bad)

endmodule

`default_nettype wire

/* tb/tb.sv */
`timescale 1ns / 1ps

module tb;
  import rsx_pkg::*;

  localparam int          WATCHDOG_LIMIT = 5000;
  localparam int          TAIL_CYCLES    = 16;
  localparam int          PHASES         = 10;
  localparam int          PHASE_ITEMS    = 26;
  localparam logic [2:0]  RADIX_ADDR     = {REG_RADIX, 2'b00};
  localparam logic [2:0]  UNUSED_ADDR    = 3'd4;
  localparam logic [31:0] INT_MIN        = 32'h8000_0000;
  localparam logic [31:0] INT_MAX        = 32'h7fff_ffff;

  typedef struct packed {
    logic [6:0] text_char;
    logic       final_char;
  } text_beat_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;   // [31:0] number
  logic        m_tvalid;
  logic        m_tready;
  logic [7:0]  m_tdata;   // [6:0] text_char, [7] zero
  logic        m_tlast;   // final_char
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  logic [5:0]  radix_model;
  text_beat_t  pending_chars[$];
  int          fail_count;
  bit          no_gaps;

  signed_integer_to_radix_text dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [6:0] symbol_of(logic [5:0] d);
    if (d < DEC_DIGITS) return ZERO_CHAR + {1'b0, d};
    return ALPHA_CHAR + {1'b0, d} - {1'b0, DEC_DIGITS};
  endfunction

  // queue the characters that one accepted number must produce
  function automatic void predict_text(logic [31:0] number);
    logic [31:0] mag;
    logic [31:0] base;
    logic [5:0]  digits[$];
    logic        neg;
    if (radix_model < RADIX_MIN || radix_model > RADIX_MAX) begin
      pending_chars.push_back('{NUL_CHAR, 1'b1});
      return;
    end
    base = {26'd0, radix_model};
    neg  = number[31];
    mag  = neg ? (32'd0 - number) : number;
    do begin
      digits.push_back(6'(mag % base));
      mag = mag / base;
    end while (mag != 0);
    if (neg) pending_chars.push_back('{MINUS_CHAR, 1'b0});
    while (digits.size() > 0) pending_chars.push_back('{symbol_of(digits.pop_back()), 1'b0});
    pending_chars.push_back('{NUL_CHAR, 1'b1});
  endfunction

  function automatic logic [31:0] pick_number();
    int          r;
    logic [31:0] v;
    r = $urandom_range(0, 99);
    if (r < 35) begin
      v = $urandom;
    end else if (r < 65) begin
      v = $urandom_range(0, 2000);
    end else if (r < 80) begin
      case ($urandom_range(0, 4))
        0: v = INT_MIN;
        1: v = INT_MAX;
        2: v = 32'd0;
        3: v = 32'hffff_ffff;
        default: v = 32'd1;
      endcase
    end else begin
      v = $urandom >> $urandom_range(1, 31);
    end
    if (r >= 35 && !(r >= 65 && r < 80) && $urandom_range(0, 1) == 1) v = 32'd0 - v;
    return v;
  endfunction

  task automatic send_number(logic [31:0] number);
    int gap;
    gap = no_gaps ? 0 : pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= number;
    do @(posedge clk); while (!s_tready);
    predict_text(number);
  endtask

  // hold the sender until every queued character has come out
  task automatic drain_results();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic apb_write(logic [2:0] addr, logic [5:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= {26'($urandom_range(0, 32'h03ff_ffff)), value};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == RADIX_ADDR) radix_model = value;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_radix_readback();
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= RADIX_ADDR;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[5:0] !== radix_model) begin
      $error("radix readback: expected %0d, actual %0d", radix_model, prdata[5:0]);
      fail_count++;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_radix(logic [5:0] value);
    drain_results();
    apb_write(RADIX_ADDR, value);
  endtask

  task automatic test_decimal_default();
    send_number(32'd0);
    send_number(32'd1);
    send_number(32'hffff_ffff);
    send_number(INT_MIN);
    send_number(INT_MAX);
    send_number(32'd9);
    send_number(32'hffff_fff6);
    send_number(32'd12345);
  endtask

  task automatic test_radix_extremes();
    set_radix(6'd2);
    send_number(INT_MIN);
    send_number(32'hffff_ffff);
    send_number(INT_MAX);
    send_number(32'd0);
    set_radix(RADIX_MAX);
    send_number(32'd35);
    send_number(32'd36);
    send_number(32'hffff_ffdd);
    send_number(INT_MIN);
    send_number(INT_MAX);
  endtask

  task automatic test_invalid_radix();
    set_radix(6'd0);
    send_number(32'hdead_beef);
    set_radix(6'd1);
    send_number(32'd0);
    set_radix(6'd37);
    send_number(INT_MIN);
    set_radix(6'd63);
    send_number(32'd77);
  endtask

  task automatic test_register_access();
    set_radix(6'd16);
    check_radix_readback();
    // write to an address with no register behind it must change nothing
    apb_write(UNUSED_ADDR, 6'd3);
    check_radix_readback();
    send_number(32'hdead_beef);
    send_number(32'hcafe_f00d);
  endtask

  task automatic test_random_numbers();
    int         r;
    logic [5:0] rad;
    for (int p = 0; p < PHASES; p++) begin
      r = $urandom_range(0, 99);
      if (p == 0) rad = 6'd2;
      else if (p == 1) rad = RADIX_MAX;
      else if (r < 15) rad = ($urandom_range(0, 1) == 1) ? 6'($urandom_range(0, 1))
                                                         : 6'($urandom_range(37, 63));
      else rad = 6'($urandom_range(2, 36));
      set_radix(rad);
      no_gaps = (p % 4 == 3);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (p == 4 && i == PHASE_ITEMS / 2) drain_results();
        send_number(pick_number());
      end
    end
    no_gaps = 1'b0;
  endtask

  // receiver pacing: runs of ready broken by stalls
  initial begin : sink_pacing
    int run_len;
    int stall_len;
    m_tready = 1'b0;
    forever begin
      run_len   = $urandom_range(1, 24);
      stall_len = no_gaps ? 0 : pick_gap();
      if (stall_len > 0) begin
        @(negedge clk);
        m_tready <= 1'b0;
        repeat (stall_len - 1) @(negedge clk);
      end
      @(negedge clk);
      m_tready <= 1'b1;
      repeat (run_len - 1) @(negedge clk);
    end
  end

  always @(posedge clk) begin
    text_beat_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_chars.size() == 0) begin
        $error("unexpected beat: text_char %0h, final_char %0b", m_tdata[6:0], m_tlast);
        fail_count++;
      end else begin
        want = pending_chars.pop_front();
        if (m_tdata[6:0] !== want.text_char) begin
          $error("text_char: expected %0h, actual %0h", want.text_char, m_tdata[6:0]);
          fail_count++;
        end
        if (m_tlast !== want.final_char) begin
          $error("final_char: expected %0b, actual %0b", want.final_char, m_tlast);
          fail_count++;
        end
        if (m_tdata[7] !== 1'b0) begin
          $error("tdata pad: expected 0, actual %0b", m_tdata[7]);
          fail_count++;
        end
      end
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("** signed_integer_to_radix_text: FAILED **");
    $finish;
  end

  initial begin
    rst         = 1'b1;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    radix_model = DEC_DIGITS;
    fail_count  = 0;
    no_gaps     = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_decimal_default();
    test_radix_extremes();
    test_invalid_radix();
    test_register_access();
    test_random_numbers();
    drain_results();

    if (pending_chars.size() != 0) fail_count++;
    if (fail_count == 0) begin
      $display("** signed_integer_to_radix_text: PASSED **");
    end else begin
      $display("** signed_integer_to_radix_text: FAILED **");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl
rtl/rsx_pkg.sv
rtl/rsx_ram.sv
rtl/rsx_front.sv
rtl/rsx_back.sv
rtl/signed_integer_to_radix_text.sv
tb/tb.sv
